// ===== rtl/bab_pkg.sv =====
// shared codes and constants for the block allocation bitmap
// no dependencies; used by bab_word_scan and block_allocation_bitmap
`default_nettype none

package bab_pkg;

    localparam int INDEX_W = 12;
    localparam int COUNT_W = 13;
    localparam int INDEX_REACH = 4096;

    localparam logic [COUNT_W-1:0] BLOCK_COUNT_RESET = 13'd4096;

    localparam logic [1:0] FUNC_MARK_USED = 2'd0;
    localparam logic [1:0] FUNC_MARK_FREE = 2'd1;
    localparam logic [1:0] FUNC_FIND_FREE = 2'd2;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_READ  = 7'b0001000,
        S_WRITE = 7'b0010000,
        S_SCAN  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    typedef struct packed {
        logic                 range_error;
        logic                 free_found;
        logic [INDEX_W-1:0]   free_index;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/bab_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module bab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bab_word_scan.sv =====
// lowest free bit of one map word, limited to the blocks still in range
// depends on bab_pkg
`default_nettype none

module bab_word_scan #(
    parameter int WORD_BITS = 32,
    parameter int BW = $clog2(WORD_BITS)
) (
    input  wire logic [WORD_BITS-1:0]        word,
    input  wire logic [bab_pkg::COUNT_W-1:0] remaining,
    output logic                             found,
    output logic [BW-1:0]                    pos
);

    logic [WORD_BITS-1:0] free_bits;

    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            free_bits[b] = ~word[b] && (bab_pkg::COUNT_W'(b) < remaining);
        end
        found = |free_bits;
        pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (free_bits[b])
            begin
                pos = BW'(b);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/block_allocation_bitmap.sv =====
// block allocation bitmap top level: request sequencer around the map ram
// depends on bab_pkg, bab_ram, bab_word_scan
// mark / free: result after the divide, read and write steps; next request taken once the result is out
// find first free: one map word per cycle, lowest free index in range wins
// one request at a time; result waits in an output register while the next is taken
// reset: block count 4096, then a clearing pass over all ceil(MAX_BLOCKS/WORD_BITS) map words
`default_nettype none

module block_allocation_bitmap #(
    parameter int MAX_BLOCKS = 4096,
    parameter int WORD_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // block_index[11:0], zeros
    input  wire logic [1:0]  s_tuser,   // func[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // range_error, free_found, free_index[11:0], zeros
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [12:0] cfg_data   // block_count
);

    localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BW = $clog2(WORD_BITS);
    localparam int CAP = (MAX_BLOCKS < bab_pkg::INDEX_REACH) ? MAX_BLOCKS
                                                             : bab_pkg::INDEX_REACH;
    localparam int K = bab_pkg::INDEX_W + BW;
    localparam int RECIP = ((2 ** K) + WORD_BITS - 1) / WORD_BITS;
    localparam int PW = bab_pkg::INDEX_W + K + 1;
    localparam int CW = bab_pkg::COUNT_W;
    localparam int IW = bab_pkg::INDEX_W;

    bab_pkg::state_t state_reg, state_next;

    logic [CW-1:0]        block_count_reg;
    logic [1:0]           op_reg, op_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic [IW-1:0]        q_reg, q_next;
    logic [BW-1:0]        bit_reg, bit_next;
    logic [AW-1:0]        clr_addr_reg, clr_addr_next;
    logic [AW-1:0]        issue_addr_reg, issue_addr_next;
    logic [CW-1:0]        issue_rem_reg, issue_rem_next;
    logic [CW-1:0]        issue_base_reg, issue_base_next;
    logic                 chk_valid_reg, chk_valid_next;
    logic [CW-1:0]        chk_rem_reg, chk_rem_next;
    logic [CW-1:0]        chk_base_reg, chk_base_next;
    bab_pkg::result_t     res_reg, res_next;
    bab_pkg::result_t     out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;

    logic [CW-1:0]        managed;
    logic [PW-1:0]        prod;
    logic [2*IW-1:0]      qw;
    logic [WORD_BITS-1:0] bit_mask;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [WORD_BITS-1:0] rd_data;
    logic                 scan_found;
    logic [BW-1:0]        scan_pos;

    bab_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS),
        .AW    (AW)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bab_word_scan #(
        .WORD_BITS (WORD_BITS),
        .BW        (BW)
    ) u_scan (
        .word      (rd_data),
        .remaining (chk_rem_reg),
        .found     (scan_found),
        .pos       (scan_pos)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == bab_pkg::S_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {2'b00, out_reg.free_index, out_reg.free_found, out_reg.range_error};

    assign managed  = (block_count_reg > CW'(CAP)) ? CW'(CAP) : block_count_reg;
    assign prod     = PW'(idx_reg) * PW'(RECIP);
    assign qw       = (2*IW)'(q_reg) * (2*IW)'(WORD_BITS);
    assign bit_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        q_next          = q_reg;
        bit_next        = bit_reg;
        clr_addr_next   = clr_addr_reg;
        issue_addr_next = issue_addr_reg;
        issue_rem_next  = issue_rem_reg;
        issue_base_next = issue_base_reg;
        chk_valid_next  = 1'b0;
        chk_rem_next    = chk_rem_reg;
        chk_base_next   = chk_base_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        wr_en           = 1'b0;
        wr_addr         = AW'(q_reg);
        wr_data         = '0;
        rd_en           = 1'b0;
        rd_addr         = AW'(q_reg);

        unique case (state_reg)
            bab_pkg::S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(MAP_WORDS - 1))
                begin
                    state_next = bab_pkg::S_IDLE;
                end
            end
            bab_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next  = s_tuser;
                    idx_next = s_tdata[IW-1:0];
                    res_next = '0;
                    unique case (s_tuser)
                        bab_pkg::FUNC_MARK_USED, bab_pkg::FUNC_MARK_FREE:
                        begin
                            if ({1'b0, s_tdata[IW-1:0]} < managed)
                            begin
                                state_next = bab_pkg::S_DIV;
                            end
                            else
                            begin
                                res_next.range_error = 1'b1;
                                state_next = bab_pkg::S_DONE;
                            end
                        end
                        bab_pkg::FUNC_FIND_FREE:
                        begin
                            issue_addr_next = '0;
                            issue_rem_next  = managed;
                            issue_base_next = '0;
                            state_next = (managed == '0) ? bab_pkg::S_DONE
                                                         : bab_pkg::S_SCAN;
                        end
                        default:
                        begin
                            state_next = bab_pkg::S_DONE;
                        end
                    endcase
                end
            end
            bab_pkg::S_DIV:
            begin
                q_next     = IW'(prod >> K);
                state_next = bab_pkg::S_READ;
            end
            bab_pkg::S_READ:
            begin
                rd_en      = 1'b1;
                bit_next   = BW'(idx_reg - qw[IW-1:0]);
                state_next = bab_pkg::S_WRITE;
            end
            bab_pkg::S_WRITE:
            begin
                wr_en      = 1'b1;
                wr_data    = (op_reg == bab_pkg::FUNC_MARK_USED) ? (rd_data | bit_mask)
                                                                : (rd_data & ~bit_mask);
                state_next = bab_pkg::S_DONE;
            end
            bab_pkg::S_SCAN:
            begin
                if (issue_rem_reg != '0)
                begin
                    rd_en           = 1'b1;
                    rd_addr         = issue_addr_reg;
                    chk_valid_next  = 1'b1;
                    chk_rem_next    = issue_rem_reg;
                    chk_base_next   = issue_base_reg;
                    issue_addr_next = issue_addr_reg + AW'(1);
                    issue_base_next = issue_base_reg + CW'(WORD_BITS);
                    issue_rem_next  = (issue_rem_reg > CW'(WORD_BITS))
                                      ? issue_rem_reg - CW'(WORD_BITS) : '0;
                end
                if (chk_valid_reg && scan_found)
                begin
                    res_next.free_found = 1'b1;
                    res_next.free_index = IW'(chk_base_reg + CW'(scan_pos));
                    chk_valid_next = 1'b0;
                    state_next = bab_pkg::S_DONE;
                end
                else if (!chk_valid_reg && issue_rem_reg == '0)
                begin
                    state_next = bab_pkg::S_DONE;
                end
            end
            bab_pkg::S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = bab_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bab_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= bab_pkg::S_CLEAR;
            block_count_reg <= bab_pkg::BLOCK_COUNT_RESET;
            clr_addr_reg    <= '0;
            issue_rem_reg   <= '0;
            chk_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            issue_rem_reg <= issue_rem_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                block_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        idx_reg        <= idx_next;
        q_reg          <= q_next;
        bit_reg        <= bit_next;
        issue_addr_reg <= issue_addr_next;
        issue_base_reg <= issue_base_next;
        chk_rem_reg    <= chk_rem_next;
        chk_base_reg   <= chk_base_next;
        res_reg        <= res_next;
        out_reg        <= out_next;
    end

endmodule

`default_nettype wire
